[design/msq_pkg.sv]
// Shared types and constants for the multi stack/queue engine.
// Beat layouts, opcode and status codes, and the node pool control bundle.
// No dependencies.
package msq_pkg;

    // Default sizes
    localparam int DEF_LISTS      = 16;
    localparam int DEF_POOL_DEPTH = 256;
    localparam int DEF_DATA_WIDTH = 32;

    // Beat field widths
    localparam int OPCODE_W  = 2;
    localparam int LIST_ID_W = 4;
    localparam int KIND_W    = 1;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;

    // Input beat: opcode, list_id, kind, value from bit 0 up
    localparam int IN_OP_LSB    = 0;
    localparam int IN_ID_LSB    = IN_OP_LSB + OPCODE_W;
    localparam int IN_KIND_LSB  = IN_ID_LSB + LIST_ID_W;
    localparam int IN_VALUE_LSB = IN_KIND_LSB + KIND_W;
    localparam int IN_USED_W    = IN_VALUE_LSB + VALUE_W;
    localparam int S_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output beat: status, popped_value from bit 0 up
    localparam int OUT_USED_W = STATUS_W + VALUE_W;
    localparam int M_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - OUT_USED_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE = 2'd0,
        OP_PUSH   = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Node pool strobes
    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic link_we;
    } msq_pool_ctrl_t;

endpackage

[design/msq_list_table.sv]
// Per-list descriptor table: exists/queue flags, head and tail pointers.
// One read port, one write port. Depends on msq_pkg only for house style.
module msq_list_table #(
    parameter int LISTS = 16,
    parameter int LW    = 4,
    parameter int PW    = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [LW-1:0] rd_idx,
    output logic          rd_exists,
    output logic          rd_queue,
    output logic [PW-1:0] rd_head,
    output logic [PW-1:0] rd_tail,
    input  logic          wr_en,
    input  logic [LW-1:0] wr_idx,
    input  logic          wr_queue,
    input  logic [PW-1:0] wr_head,
    input  logic [PW-1:0] wr_tail
);
    import msq_pkg::*;

    logic [LISTS-1:0] exists_reg;
    logic [LISTS-1:0] queue_reg;
    logic [PW-1:0]    head_reg [LISTS];
    logic [PW-1:0]    tail_reg [LISTS];

    // flags need reset; pointers are rewritten by create
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg <= '0;
            queue_reg  <= '0;
        end
        else if (wr_en)
        begin
            exists_reg[wr_idx] <= 1'b1;
            queue_reg[wr_idx]  <= wr_queue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            head_reg[wr_idx] <= wr_head;
            tail_reg[wr_idx] <= wr_tail;
        end
    end

    assign rd_exists = exists_reg[rd_idx];
    assign rd_queue  = queue_reg[rd_idx];
    assign rd_head   = head_reg[rd_idx];
    assign rd_tail   = tail_reg[rd_idx];

endmodule

[design/msq_node_pool.sv]
// Node pool: value and link memories, one registered read port shared by
// both, one write port each. Depends on msq_pkg (msq_pool_ctrl_t).
module msq_node_pool #(
    parameter int POOL_DEPTH = 256,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 8,
    parameter int PW         = 9
) (
    input  logic                   clk,
    input  msq_pkg::msq_pool_ctrl_t ctrl,
    input  logic [AW-1:0]          rd_addr,
    output logic [DATA_WIDTH-1:0]  rd_value,
    output logic [PW-1:0]          rd_link,
    input  logic [AW-1:0]          val_waddr,
    input  logic [DATA_WIDTH-1:0]  val_wdata,
    input  logic [AW-1:0]          link_waddr,
    input  logic [PW-1:0]          link_wdata
);
    import msq_pkg::*;

    logic [DATA_WIDTH-1:0] val_mem  [POOL_DEPTH];
    logic [PW-1:0]         link_mem [POOL_DEPTH];
    logic [DATA_WIDTH-1:0] rd_value_reg;
    logic [PW-1:0]         rd_link_reg;

    // read-first; read data holds until the next read strobe
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_value_reg <= val_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
        if (ctrl.val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (ctrl.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_link  = rd_link_reg;

endmodule

[design/multi_stack_queue_engine.sv]
// Top level of the multi stack/queue engine: handshakes, sequencer,
// free list and fresh counter. Uses msq_pkg, msq_list_table, msq_node_pool.
//
// Usage
//   Input stream (s_axis_*): one beat per command. tdata carries opcode
//   (create / push / pop), list_id, kind (stack or queue, for create) and
//   the value to push. Output stream (m_axis_*): exactly one beat per
//   command, carrying status and the popped value (zero unless a pop
//   succeeded). Results leave in command order.
//   Timing: a command is accepted in the idle state; the same edge starts
//   the node memory read (head node for pop, free-list head for push).
//   The execute step then decides, writes the memories and loads the result
//   register that drives m_axis_tvalid, waiting while the result slot is full.
//   A command is accepted only in the idle state; a push onto a non-empty
//   queue adds a link step, as the old tail's link needs a second write.
//   Stalls: the result register is a single slot. While it is full and
//   m_axis_tready is low, the block may accept one more command and then
//   holds it, with no side effects, until the slot frees.
//   Reset: all lists absent, free list empty, fresh counter zero. The node
//   memories need no clearing; a node is always written before it is read.
module multi_stack_queue_engine #(
    parameter int LISTS      = msq_pkg::DEF_LISTS,
    parameter int POOL_DEPTH = msq_pkg::DEF_POOL_DEPTH,
    parameter int DATA_WIDTH = msq_pkg::DEF_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] opcode, [5:2] list_id, [6] kind, [38:7] value, [39] zero
    input  logic [msq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] status, [34:3] popped_value, [39:35] zero
    output logic [msq_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import msq_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LINK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // input beat fields
    opcode_t               in_op;
    logic [LIST_ID_W-1:0]  in_id;
    logic                  in_kind;
    logic [VALUE_W-1:0]    in_value;

    // command held during execution
    opcode_t               op_reg;
    logic                  id_ok_reg;
    logic [LW-1:0]         idx_reg;
    logic                  kind_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic                  ent_exists_reg;
    logic                  ent_queue_reg;
    logic [PW-1:0]         ent_head_reg;
    logic [PW-1:0]         ent_tail_reg;

    // pool allocation state
    logic [PW-1:0]         free_head_reg, free_head_next;
    logic [PW-1:0]         fresh_reg, fresh_next;

    // deferred old-tail link write
    logic [AW-1:0]         tail_link_reg, tail_link_next;
    logic [AW-1:0]         node_reg, node_next;

    // result slot
    logic                  out_valid_reg;
    status_t               out_status_reg, status_c;
    logic [DATA_WIDTH-1:0] out_value_reg, popped_c;
    logic                  out_load;
    logic                  out_free;
    logic                  acc;

    // list table ports
    logic                  tbl_exists, tbl_queue;
    logic [PW-1:0]         tbl_head, tbl_tail;
    logic                  tbl_we;
    logic                  tbl_wr_queue;
    logic [PW-1:0]         tbl_wr_head, tbl_wr_tail;

    // pool ports
    msq_pool_ctrl_t        pool_ctrl;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [PW-1:0]         rd_link;
    logic [AW-1:0]         val_waddr;
    logic [AW-1:0]         link_waddr;
    logic [PW-1:0]         link_wdata;

    // push allocation
    logic                  have_free, have_fresh;
    logic [AW-1:0]         alloc_node;
    logic                  q_empty;

    assign in_op    = opcode_t'(s_axis_tdata[IN_OP_LSB +: OPCODE_W]);
    assign in_id    = s_axis_tdata[IN_ID_LSB +: LIST_ID_W];
    assign in_kind  = s_axis_tdata[IN_KIND_LSB];
    assign in_value = s_axis_tdata[IN_VALUE_LSB +: VALUE_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    msq_list_table #(
        .LISTS (LISTS),
        .LW    (LW),
        .PW    (PW)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (LW'(in_id)),
        .rd_exists (tbl_exists),
        .rd_queue  (tbl_queue),
        .rd_head   (tbl_head),
        .rd_tail   (tbl_tail),
        .wr_en     (tbl_we),
        .wr_idx    (idx_reg),
        .wr_queue  (tbl_wr_queue),
        .wr_head   (tbl_wr_head),
        .wr_tail   (tbl_wr_tail)
    );

    msq_node_pool #(
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .PW         (PW)
    ) u_pool (
        .clk        (clk),
        .ctrl       (pool_ctrl),
        .rd_addr    (rd_addr),
        .rd_value   (rd_value),
        .rd_link    (rd_link),
        .val_waddr  (val_waddr),
        .val_wdata  (val_reg),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata)
    );

    // Free list first, then never-used nodes
    assign have_free  = (free_head_reg < NIL);
    assign have_fresh = (fresh_reg < NIL);
    assign alloc_node = have_free ? AW'(free_head_reg) : AW'(fresh_reg);
    assign q_empty    = (ent_head_reg >= NIL) || (ent_tail_reg >= NIL);

    always_comb
    begin
        state_next        = state_reg;
        free_head_next    = free_head_reg;
        fresh_next        = fresh_reg;
        tail_link_next    = tail_link_reg;
        node_next         = node_reg;
        tbl_we            = 1'b0;
        tbl_wr_queue      = ent_queue_reg;
        tbl_wr_head       = ent_head_reg;
        tbl_wr_tail       = ent_tail_reg;
        pool_ctrl         = '0;
        pool_ctrl.rd_en   = acc;
        // pop reads the head node, push reads the free-list head
        rd_addr           = (in_op == OP_POP) ? AW'(tbl_head) : AW'(free_head_reg);
        val_waddr         = alloc_node;
        link_waddr        = alloc_node;
        link_wdata        = NIL;
        out_load          = 1'b0;
        status_c          = ST_OK;
        popped_c          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == OP_NONE)
                    begin
                        status_c = ST_OK;
                    end
                    else if (!id_ok_reg)
                    begin
                        status_c = ST_MISSING;
                    end
                    else if (op_reg == OP_CREATE)
                    begin
                        if (ent_exists_reg)
                        begin
                            status_c = ST_EXISTS;
                        end
                        else
                        begin
                            tbl_we       = 1'b1;
                            tbl_wr_queue = kind_reg;
                            tbl_wr_head  = NIL;
                            tbl_wr_tail  = NIL;
                        end
                    end
                    else if (!ent_exists_reg)
                    begin
                        status_c = ST_MISSING;
                    end
                    else if (op_reg == OP_PUSH)
                    begin
                        if (!have_free && !have_fresh)
                        begin
                            status_c = ST_FULL;
                        end
                        else
                        begin
                            if (have_free)
                            begin
                                free_head_next = rd_link;
                            end
                            else
                            begin
                                fresh_next = fresh_reg + PW'(1);
                            end
                            pool_ctrl.val_we  = 1'b1;
                            pool_ctrl.link_we = 1'b1;
                            tbl_we            = 1'b1;
                            if (ent_queue_reg)
                            begin
                                link_wdata  = NIL;
                                tbl_wr_tail = PW'(alloc_node);
                                if (q_empty)
                                begin
                                    tbl_wr_head = PW'(alloc_node);
                                end
                                else
                                begin
                                    // old tail must point at the new node
                                    tail_link_next = AW'(ent_tail_reg);
                                    node_next      = alloc_node;
                                    state_next     = ST_LINK;
                                end
                            end
                            else
                            begin
                                link_wdata  = ent_head_reg;
                                tbl_wr_head = PW'(alloc_node);
                            end
                        end
                    end
                    else
                    begin
                        // pop
                        if (ent_head_reg >= NIL)
                        begin
                            status_c = ST_EMPTY;
                        end
                        else
                        begin
                            popped_c          = rd_value;
                            tbl_we            = 1'b1;
                            pool_ctrl.link_we = 1'b1;
                            link_waddr        = AW'(ent_head_reg);
                            link_wdata        = free_head_reg;
                            free_head_next    = ent_head_reg;
                            if (rd_link >= NIL)
                            begin
                                tbl_wr_head = NIL;
                                tbl_wr_tail = NIL;
                            end
                            else
                            begin
                                tbl_wr_head = rd_link;
                            end
                        end
                    end
                end
            end
            ST_LINK:
            begin
                pool_ctrl.link_we = 1'b1;
                link_waddr        = tail_link_reg;
                link_wdata        = PW'(node_reg);
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= NIL;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg         <= in_op;
            id_ok_reg      <= (32'(in_id) < 32'(LISTS));
            idx_reg        <= LW'(in_id);
            kind_reg       <= in_kind;
            val_reg        <= DATA_WIDTH'(in_value);
            ent_exists_reg <= tbl_exists;
            ent_queue_reg  <= tbl_queue;
            ent_head_reg   <= tbl_head;
            ent_tail_reg   <= tbl_tail;
        end
        tail_link_reg <= tail_link_next;
        node_reg      <= node_next;
        if (out_load)
        begin
            out_status_reg <= status_c;
            out_value_reg  <= popped_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, VALUE_W'(out_value_reg), out_status_reg};

`ifndef SYNTHESIS
    // one command in flight: no accept in the cycle after an accept
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !s_axis_tready)
        else $error("command accepted while another executes");

    // fresh counter never passes the pool size
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NIL)
        else $error("fresh counter beyond pool");

    // result slot only loads from the execute step, and never over a waiting beat
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == ST_EXEC) && out_free)
        else $error("result loaded out of sequence");

    // tail link write only follows an execute step
    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK) |-> ($past(state_reg) == ST_EXEC))
        else $error("link step without execute");

    // new node never equals the old tail it gets linked from
    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK) |-> (tail_link_reg != node_reg))
        else $error("tail linked to itself");
`endif

endmodule
